// File: design/sip_pkg.sv
// Shared types and constants for the piecewise-cubic Simpson integrator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

  localparam int BND_W     = 28;  // bound registers, signed fixed point
  localparam int OUT_W     = 30;  // integral result width
  localparam int LVL_W     = 5;   // refinement level width
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'd1;

  // Weight class of one integrand sample: end term x1, S1 x2, S2 x4
  typedef enum logic [1:0] {
    TAG_END,
    TAG_S1,
    TAG_S2
  } tag_t;

  // Abscissa source for an evaluation
  typedef enum logic [2:0] {
    X_A,
    X_B,
    X_A_HALF,
    X_L_STEP,
    X_L_HALF
  } xsel_t;

  typedef struct packed {
    logic  load;      // capture refine level
    logic  setup;     // interval count, start index, clear sum
    logic  init;      // first left node
    logic  issue;     // start one integrand evaluation
    xsel_t xsel;
    tag_t  tag;
    logic  step;      // advance to next interval
    logic  div_load;
    logic  div_step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic cnt_zero;
    logic loop_done;
    logic last_iter;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/sip_in_if.sv
// Request channel of the Simpson integrator: valid/ready plus refine level.
// Depends on sip_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sip_in_if import sip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] refine_level;

  modport source (output valid, output refine_level, input ready);
  modport sink   (input valid, input refine_level, output ready);
endinterface

`default_nettype wire

// File: design/sip_out_if.sv
// Result channel of the Simpson integrator: valid/ready plus integral and flag.
// Depends on sip_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sip_out_if import sip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] integral;
  logic             bad_bounds;

  modport source (output valid, output integral, output bad_bounds, input ready);
  modport sink   (input valid, input integral, input bad_bounds, output ready);
endinterface

`default_nettype wire

// File: design/sip_feval.sv
// Pipelined integrand f(x) = 1 - x^3 on [-1,1], zero outside; five stages.
// Depends on sip_pkg for the weight tag type.
`timescale 1ns / 1ps
`default_nettype none

module sip_feval import sip_pkg::*; #(
  parameter int FRAC_BITS = 24,
  parameter int XW        = 30
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   iss,
  input  tag_t                   iss_tag,
  input  logic signed [XW-1:0]   iss_x,
  output logic                   f_vld,
  output tag_t                   f_tag,
  output logic [FRAC_BITS+1:0]   f,
  output logic                   busy
);

  localparam int MW = FRAC_BITS + 1;
  localparam int FW = FRAC_BITS + 2;
  localparam logic signed [XW-1:0] ONE_X = XW'(64'd1 << FRAC_BITS);
  localparam logic [FW-1:0]        ONE_F = FW'(64'd1 << FRAC_BITS);

  logic [4:0]            vld_r;
  tag_t                  tag_r [5];
  logic signed [XW-1:0]  x0_r;
  logic                  zero1_r, neg1_r, zero2_r, neg2_r, zero3_r, neg3_r;
  logic [MW-1:0]         mag1_r, mag2_r, sq2_r, cube3_r;
  logic [FW-1:0]         f_r;
  logic [2*MW-1:0]       prod1_w, prod2_w;
  logic signed [XW-1:0]  negx_w;

  assign negx_w  = -x0_r;
  assign prod1_w = (2*MW)'(mag1_r) * (2*MW)'(mag1_r);
  assign prod2_w = (2*MW)'(sq2_r) * (2*MW)'(mag2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], iss};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= iss_tag;
    for (int k = 1; k < 5; k++) begin
      tag_r[k] <= tag_r[k-1];
    end
    x0_r    <= iss_x;
    // stage 1: range test and magnitude
    zero1_r <= (x0_r < -ONE_X) || (x0_r > ONE_X);
    neg1_r  <= x0_r[XW-1];
    mag1_r  <= x0_r[XW-1] ? negx_w[MW-1:0] : x0_r[MW-1:0];
    // stage 2: truncated square
    sq2_r   <= prod1_w[FRAC_BITS +: MW];
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    zero2_r <= zero1_r;
    // stage 3: truncated cube
    cube3_r <= prod2_w[FRAC_BITS +: MW];
    neg3_r  <= neg2_r;
    zero3_r <= zero2_r;
    // stage 4: apply sign
    if (zero3_r) begin
      f_r <= '0;
    end else if (neg3_r) begin
      f_r <= ONE_F + FW'(cube3_r);
    end else begin
      f_r <= ONE_F - FW'(cube3_r);
    end
  end

  assign f_vld = vld_r[4];
  assign f_tag = tag_r[4];
  assign f     = f_r;
  assign busy  = |vld_r;

endmodule

`default_nettype wire

// File: design/sip_dp.sv
// Datapath: bound registers, interval bookkeeping, weighted sum, divide by
// six and output holding register. Depends on sip_pkg, sip_feval.
`timescale 1ns / 1ps
`default_nettype none

module sip_dp import sip_pkg::*; #(
  parameter int FRAC_BITS  = 24,
  parameter int MAX_REFINE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BND_W-1:0]      cfg_data,
  input  logic [LVL_W-1:0]      refine_level,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_integral,
  output logic                  out_bad
);

  localparam int NMAX = (MAX_REFINE < FRAC_BITS - 1) ? MAX_REFINE : FRAC_BITS - 1;
  localparam int NW   = $clog2(NMAX + 1);
  localparam int SHW  = $clog2(FRAC_BITS + 1);
  localparam int XW   = ((BND_W > FRAC_BITS + 1) ? BND_W : FRAC_BITS + 1) + 2;
  localparam int DW   = BND_W + 1;
  localparam int CW   = BND_W;
  localparam int FW   = FRAC_BITS + 2;
  localparam int SW0  = FRAC_BITS + NMAX + 7;
  localparam int SW   = (SW0 > OUT_W + 3) ? SW0 : OUT_W + 3;

  localparam logic signed [XW-1:0]    ONE_X  = XW'(64'd1 << FRAC_BITS);
  localparam logic [LVL_W-1:0]        NMAX_L = LVL_W'(NMAX);
  localparam logic signed [BND_W-1:0] A_RST  = BND_W'(-(64'sd2 <<< FRAC_BITS));
  localparam logic signed [BND_W-1:0] B_RST  = BND_W'(64'sd2 <<< FRAC_BITS);
  // dividends from 6*2^OUT_W up saturate; below it v/6 = (v>>1)/3 on 32 bits
  localparam logic [SW-1:0]           SAT_LIM = SW'(64'd6 << OUT_W);
  localparam logic [31:0]             RECIP3  = 32'hAAAA_AAAB;

  logic signed [BND_W-1:0] a_r, b_r;
  logic [NW-1:0]           n_r;
  logic [SHW-1:0]          sh_r;
  logic [CW-1:0]           count_r, i_r;
  logic signed [XW-1:0]    left_r;
  logic [SW-1:0]           tot_r, div_r;
  logic [OUT_W-1:0]        quo_r;
  logic                    out_vld_r, out_bad_r;
  logic [OUT_W-1:0]        out_res_r;

  logic signed [XW-1:0]    a_x, b_x, h_w, half_w, d_w, lofs_w, x_w, left_nxt;
  logic signed [DW-1:0]    diff_w;
  logic [XW-1:0]           dsh_w;
  logic [CW-1:0]           i0c_w, i0_w, cnt_w;
  logic                    bad_w;
  logic                    f_vld, fe_busy;
  tag_t                    f_tag;
  logic [FW-1:0]           f_w;
  logic [SW-1:0]           term_w;
  logic                    big_w;
  logic [31:0]             hv_w;
  logic [63:0]             mul_w;
  logic [OUT_W-1:0]        sat_w;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= A_RST;
      b_r <= B_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOWER) begin
        a_r <= cfg_data;
      end else if (cfg_index == CFG_UPPER) begin
        b_r <= cfg_data;
      end
    end
  end

  assign a_x    = XW'(a_r);
  assign b_x    = XW'(b_r);
  assign h_w    = {{(XW-1){1'b0}}, 1'b1} << sh_r;
  assign half_w = h_w >> 1;
  assign bad_w  = (b_r <= a_r);
  assign diff_w = DW'(b_r) - DW'(a_r);
  assign cnt_w  = diff_w[BND_W-1:0] >> sh_r;

  // skip intervals lying wholly below -1
  assign d_w    = -ONE_X - h_w - a_x;
  assign dsh_w  = d_w >> sh_r;
  assign i0c_w  = dsh_w[CW-1:0];
  assign i0_w   = (!d_w[XW-1] && (d_w != '0) && (i0c_w > CW'(1))) ? i0c_w : CW'(1);

  assign lofs_w   = (XW'(i_r) - XW'(1)) << sh_r;
  assign left_nxt = a_x + lofs_w;

  always_comb begin
    case (cmd.xsel)
      X_A:      x_w = a_x;
      X_B:      x_w = b_x;
      X_A_HALF: x_w = a_x + half_w;
      X_L_STEP: x_w = left_r + h_w;
      X_L_HALF: x_w = left_r + half_w;
      default:  x_w = a_x;
    endcase
  end

  sip_feval #(
    .FRAC_BITS (FRAC_BITS),
    .XW        (XW)
  ) u_feval (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (cmd.issue),
    .iss_tag (cmd.tag),
    .iss_x   (x_w),
    .f_vld   (f_vld),
    .f_tag   (f_tag),
    .f       (f_w),
    .busy    (fe_busy)
  );

  always_comb begin
    case (f_tag)
      TAG_END: term_w = SW'(f_w);
      TAG_S1:  term_w = SW'(f_w) << 1;
      TAG_S2:  term_w = SW'(f_w) << 2;
      default: term_w = '0;
    endcase
  end

  // divide by six: saturate check, then reciprocal multiply for /3 of v>>1
  assign big_w = (div_r >= SAT_LIM);
  assign hv_w  = div_r[32:1];
  assign mul_w = 64'(hv_w) * 64'(RECIP3);
  assign sat_w = big_w ? '1 : mul_w[33 +: OUT_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (refine_level > NMAX_L) begin
        n_r  <= NW'(NMAX);
        sh_r <= SHW'(FRAC_BITS - NMAX);
      end else begin
        n_r  <= refine_level[NW-1:0];
        sh_r <= SHW'(FRAC_BITS) - SHW'(refine_level);
      end
    end
    if (cmd.setup) begin
      count_r <= cnt_w;
      i_r     <= i0_w;
    end else if (cmd.step) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.init) begin
      left_r <= left_nxt;
    end else if (cmd.step) begin
      left_r <= left_r + h_w;
    end
    if (cmd.setup) begin
      tot_r <= '0;
    end else if (f_vld) begin
      tot_r <= tot_r + term_w;
    end
    if (cmd.div_load) begin
      div_r <= tot_r >> n_r;
    end
    if (cmd.div_step) begin
      quo_r <= sat_w;
    end
    if (cmd.out_load) begin
      out_res_r <= bad_w ? '0 : quo_r;
      out_bad_r <= bad_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign sts.bad        = bad_w;
  assign sts.cnt_zero   = (count_r == '0);
  assign sts.loop_done  = (i_r > count_r) || (left_r > ONE_X);
  assign sts.last_iter  = (i_r == count_r);
  assign sts.pipe_empty = !fe_busy;
  assign sts.out_free   = !out_vld_r || out_ready;

  assign out_valid    = out_vld_r;
  assign out_integral = out_res_r;
  assign out_bad      = out_bad_r;

`ifndef SYNTHESIS
  a_s1_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.xsel == X_L_STEP) |-> (i_r < count_r))
    else $error("interior node issued on last interval");
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !f_vld)
    else $error("integrand sample arrived during divide");
`endif

endmodule

`default_nettype wire

// File: design/sip_ctrl.sv
// Controller FSM: sequences setup, integrand evaluations, drain, divide and
// result hand-off. Depends on sip_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sip_ctrl import sip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_INIT  = 4'd3;
  localparam logic [3:0] ST_EVA   = 4'd4;
  localparam logic [3:0] ST_EVB   = 4'd5;
  localparam logic [3:0] ST_EVZ   = 4'd6;
  localparam logic [3:0] ST_LOOP  = 4'd7;
  localparam logic [3:0] ST_LOOP2 = 4'd8;
  localparam logic [3:0] ST_DRAIN = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.bad ? ST_DONE : ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_EVA;
      end
      ST_EVA: begin
        cmd.issue = 1'b1;
        cmd.xsel  = X_A;
        cmd.tag   = TAG_END;
        state_nxt = ST_EVB;
      end
      ST_EVB: begin
        cmd.issue = 1'b1;
        cmd.xsel  = X_B;
        cmd.tag   = TAG_END;
        state_nxt = sts.cnt_zero ? ST_EVZ : ST_LOOP;
      end
      ST_EVZ: begin
        // less than one interval: single midpoint sample
        cmd.issue = 1'b1;
        cmd.xsel  = X_A_HALF;
        cmd.tag   = TAG_S2;
        state_nxt = ST_DRAIN;
      end
      ST_LOOP: begin
        if (sts.loop_done) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.issue = !sts.last_iter;
          cmd.xsel  = X_L_STEP;
          cmd.tag   = TAG_S1;
          state_nxt = ST_LOOP2;
        end
      end
      ST_LOOP2: begin
        cmd.issue = 1'b1;
        cmd.xsel  = X_L_HALF;
        cmd.tag   = TAG_S2;
        cmd.step  = 1'b1;
        state_nxt = ST_LOOP;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.div_load = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> sts.pipe_empty)
    else $error("evaluation pipeline busy while idle");
`endif

endmodule

`default_nettype wire

// File: design/simpson_integrate_piecewise_cubic.sv
// Composite Simpson integral of f(x) = 1 - x^3 (zero outside [-1,1]) between
// the lower_bound and upper_bound registers, FRAC_BITS fraction bits. Each
// request carries a refine level n (step 2^-n, clamped); one result comes
// back per request, with bad_bounds set and integral zero when upper <= lower.
// One request is worked at a time. The walk covers the intervals between
// roughly -1-3h and min(b,1), two integrand samples each (only the midpoint
// on the interval ending at b), one sample per cycle through a single
// five-stage multiply pipeline; the divide by six is a reciprocal multiply
// with saturation. A finished result waits in an output register.
`timescale 1ns / 1ps
`default_nettype none

module simpson_integrate_piecewise_cubic import sip_pkg::*; #(
  parameter int FRAC_BITS  = 24,
  parameter int MAX_REFINE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BND_W-1:0]     cfg_data,
  sip_in_if.sink               in_req,
  sip_out_if.source            out_res
);

  cmd_t cmd;
  sts_t sts;

  sip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sip_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_REFINE (MAX_REFINE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .refine_level (in_req.refine_level),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_res.ready),
    .out_valid    (out_res.valid),
    .out_integral (out_res.integral),
    .out_bad      (out_res.bad_bounds)
  );

endmodule

`default_nettype wire
